/* rtl/sgrpen_pkg.sv */
package sgrpen_pkg;

    // colour kinds
    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    // sgr codes and code ranges
    localparam logic [15:0] SGR_RESET          = 16'd0;
    localparam logic [15:0] SGR_SET_LAST       = 16'd9;
    localparam logic [15:0] SGR_CLR_BASE       = 16'd20;
    localparam logic [15:0] SGR_CLR_LAST       = 16'd29;
    localparam logic [15:0] SGR_FG_BASE        = 16'd30;
    localparam logic [15:0] SGR_FG_LAST        = 16'd37;
    localparam logic [15:0] SGR_EXT_FG         = 16'd38;
    localparam logic [15:0] SGR_DEFAULT_FG     = 16'd39;
    localparam logic [15:0] SGR_BG_BASE        = 16'd40;
    localparam logic [15:0] SGR_BG_LAST        = 16'd47;
    localparam logic [15:0] SGR_EXT_BG         = 16'd48;
    localparam logic [15:0] SGR_DEFAULT_BG     = 16'd49;
    localparam logic [15:0] SGR_FG_BRIGHT_BASE = 16'd90;
    localparam logic [15:0] SGR_FG_BRIGHT_LAST = 16'd97;
    localparam logic [15:0] SGR_BG_BRIGHT_BASE = 16'd100;
    localparam logic [15:0] SGR_BG_BRIGHT_LAST = 16'd107;

    // extended colour kind selectors
    localparam logic [15:0] EXT_KIND_INDEX = 16'd5;
    localparam logic [15:0] EXT_KIND_RGB   = 16'd2;

    // attribute masks, set codes indexed by code, clear codes by code minus 20
    localparam logic [7:0] ATTR_SET_MASK [0:9] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h10, 8'h20, 8'h40, 8'h80
    };
    localparam logic [7:0] ATTR_CLR_MASK [0:9] = '{
        8'h00, 8'h03, 8'h03, 8'h04, 8'h08, 8'h10, 8'h00, 8'h20, 8'h40, 8'h80
    };

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_KIND       = 3'd1,
        PH_INDEX      = 3'd2,
        PH_RED_OR_SLOT = 3'd3,
        PH_GREEN      = 3'd4,
        PH_BLUE       = 3'd5,
        PH_RED        = 3'd6
    } t_ext_phase;

    typedef struct packed {
        logic [7:0]  attrs;
        logic [1:0]  fg_kind;
        logic [23:0] fg_value;
        logic [1:0]  bg_kind;
        logic [23:0] bg_value;
        logic        target_back;
        t_ext_phase  phase;
        logic [15:0] partial_rgb;
    } t_pen;

    localparam t_pen PEN_RESET = '{
        attrs:       8'd0,
        fg_kind:     KIND_DEFAULT,
        fg_value:    24'd0,
        bg_kind:     KIND_DEFAULT,
        bg_value:    24'd0,
        target_back: 1'b0,
        phase:       PH_IDLE,
        partial_rgb: 16'd0
    };

endpackage

/* rtl/sgrpen_step.sv */
module sgrpen_step (
    input  sgrpen_pkg::t_pen i_pen,
    input  logic [15:0]      i_param_value,
    input  logic             i_param_omitted,
    input  logic             i_last_param,
    input  logic             i_empty_sequence,
    output sgrpen_pkg::t_pen o_pen
);

    function automatic sgrpen_pkg::t_pen set_ext(sgrpen_pkg::t_pen p, logic [1:0] kind,
                                                 logic [23:0] val);
        sgrpen_pkg::t_pen q;
        q = p;
        if (p.target_back) begin
            q.bg_kind  = kind;
            q.bg_value = val;
        end else begin
            q.fg_kind  = kind;
            q.fg_value = val;
        end
        q.phase       = sgrpen_pkg::PH_IDLE;
        q.partial_rgb = 16'd0;
        return q;
    endfunction

    logic [15:0]      v;
    logic [7:0]       chan;
    logic [15:0]      d_fg;
    logic [15:0]      d_bg;
    logic [15:0]      d_fgb;
    logic [15:0]      d_bgb;
    logic [15:0]      d_clr;
    sgrpen_pkg::t_pen s;

    assign v     = i_param_omitted ? 16'd0 : i_param_value;
    assign chan  = (|v[15:8]) ? 8'hFF : v[7:0];
    assign d_fg  = v - sgrpen_pkg::SGR_FG_BASE;
    assign d_bg  = v - sgrpen_pkg::SGR_BG_BASE;
    assign d_fgb = v - sgrpen_pkg::SGR_FG_BRIGHT_BASE;
    assign d_bgb = v - sgrpen_pkg::SGR_BG_BRIGHT_BASE;
    assign d_clr = v - sgrpen_pkg::SGR_CLR_BASE;

    always_comb begin
        s = i_pen;
        unique case (i_pen.phase)
            sgrpen_pkg::PH_KIND: begin
                if (v == sgrpen_pkg::EXT_KIND_INDEX) begin
                    s.phase = sgrpen_pkg::PH_INDEX;
                end else if (v == sgrpen_pkg::EXT_KIND_RGB) begin
                    s.phase = sgrpen_pkg::PH_RED_OR_SLOT;
                end else begin
                    s = set_ext(i_pen, sgrpen_pkg::KIND_DEFAULT, 24'd0);
                end
            end
            sgrpen_pkg::PH_INDEX: begin
                s = set_ext(i_pen, sgrpen_pkg::KIND_PALETTE, {16'd0, chan});
            end
            sgrpen_pkg::PH_RED_OR_SLOT: begin
                // an omitted colourspace slot is skipped once
                if (i_param_omitted) begin
                    s.phase = sgrpen_pkg::PH_RED;
                end else begin
                    s.partial_rgb = {chan, 8'd0};
                    s.phase       = sgrpen_pkg::PH_GREEN;
                end
            end
            sgrpen_pkg::PH_RED: begin
                s.partial_rgb = {chan, 8'd0};
                s.phase       = sgrpen_pkg::PH_GREEN;
            end
            sgrpen_pkg::PH_GREEN: begin
                s.partial_rgb = {i_pen.partial_rgb[15:8], chan};
                s.phase       = sgrpen_pkg::PH_BLUE;
            end
            sgrpen_pkg::PH_BLUE: begin
                s = set_ext(i_pen, sgrpen_pkg::KIND_RGB, {i_pen.partial_rgb, chan});
            end
            default: begin
                // idle, and the unused phase code
                s.phase = sgrpen_pkg::PH_IDLE;
                priority if (v == sgrpen_pkg::SGR_RESET) begin
                    s.attrs    = 8'd0;
                    s.fg_kind  = sgrpen_pkg::KIND_DEFAULT;
                    s.fg_value = 24'd0;
                    s.bg_kind  = sgrpen_pkg::KIND_DEFAULT;
                    s.bg_value = 24'd0;
                end else if (v <= sgrpen_pkg::SGR_SET_LAST) begin
                    s.attrs = i_pen.attrs | sgrpen_pkg::ATTR_SET_MASK[v[3:0]];
                end else if (v >= sgrpen_pkg::SGR_CLR_BASE && v <= sgrpen_pkg::SGR_CLR_LAST) begin
                    s.attrs = i_pen.attrs & ~sgrpen_pkg::ATTR_CLR_MASK[d_clr[3:0]];
                end else if (v >= sgrpen_pkg::SGR_FG_BASE && v <= sgrpen_pkg::SGR_FG_LAST) begin
                    s.fg_kind  = sgrpen_pkg::KIND_PALETTE;
                    s.fg_value = {21'd0, d_fg[2:0]};
                end else if (v == sgrpen_pkg::SGR_EXT_FG) begin
                    s.target_back = 1'b0;
                    s.phase       = sgrpen_pkg::PH_KIND;
                    s.partial_rgb = 16'd0;
                end else if (v == sgrpen_pkg::SGR_DEFAULT_FG) begin
                    s.fg_kind  = sgrpen_pkg::KIND_DEFAULT;
                    s.fg_value = 24'd0;
                end else if (v >= sgrpen_pkg::SGR_BG_BASE && v <= sgrpen_pkg::SGR_BG_LAST) begin
                    s.bg_kind  = sgrpen_pkg::KIND_PALETTE;
                    s.bg_value = {21'd0, d_bg[2:0]};
                end else if (v == sgrpen_pkg::SGR_EXT_BG) begin
                    s.target_back = 1'b1;
                    s.phase       = sgrpen_pkg::PH_KIND;
                    s.partial_rgb = 16'd0;
                end else if (v == sgrpen_pkg::SGR_DEFAULT_BG) begin
                    s.bg_kind  = sgrpen_pkg::KIND_DEFAULT;
                    s.bg_value = 24'd0;
                end else if (v >= sgrpen_pkg::SGR_FG_BRIGHT_BASE &&
                             v <= sgrpen_pkg::SGR_FG_BRIGHT_LAST) begin
                    s.fg_kind  = sgrpen_pkg::KIND_PALETTE;
                    s.fg_value = {20'd0, 1'b1, d_fgb[2:0]};
                end else if (v >= sgrpen_pkg::SGR_BG_BRIGHT_BASE &&
                             v <= sgrpen_pkg::SGR_BG_BRIGHT_LAST) begin
                    s.bg_kind  = sgrpen_pkg::KIND_PALETTE;
                    s.bg_value = {20'd0, 1'b1, d_bgb[2:0]};
                end else begin
                    s.attrs = i_pen.attrs;
                end
            end
        endcase
    end

    always_comb begin
        o_pen = s;
        if (i_empty_sequence) begin
            o_pen = sgrpen_pkg::PEN_RESET;
        end else if (i_last_param && s.phase != sgrpen_pkg::PH_IDLE) begin
            // sequence ended early: missing operands read as zero
            if (s.phase == sgrpen_pkg::PH_KIND) begin
                o_pen = set_ext(s, sgrpen_pkg::KIND_DEFAULT, 24'd0);
            end else if (s.phase == sgrpen_pkg::PH_INDEX) begin
                o_pen = set_ext(s, sgrpen_pkg::KIND_PALETTE, 24'd0);
            end else begin
                o_pen = set_ext(s, sgrpen_pkg::KIND_RGB, {s.partial_rgb, 8'd0});
            end
        end
    end

endmodule

/* rtl/sgr_pen_attribute_decoder_top.sv */
// sgr pen attribute decoder
//
// takes the parameters of one sgr control sequence, one parameter per transfer
// on the input channel (i_in_valid / o_in_stall), and keeps the current pen:
// eight attribute bits, a foreground and a background colour. after every
// parameter the whole pen is sent as one transfer on the output channel
// (o_out_valid / i_out_stall); o_pen_valid is low while an extended colour
// (38 or 48) still waits for operands.
//
// the pen for a parameter is decoded from the input register and offered
// from the pen register once that register advances. throughput: one
// parameter per cycle unless the output stalls; the path is an input
// register, one pass of decode logic, and the pen register, which is also
// the result. the pen register advances only when the previous result has
// been taken, so under output stall the input register holds one more
// parameter and o_in_stall rises once that register is full.
//
// reset (synchronous, active low) clears the pen to default colours and no
// attributes, drops any pending extended colour and empties both registers.
module sgr_pen_attribute_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_param_value,
    input  logic        i_param_omitted,
    input  logic        i_last_param,
    input  logic        i_empty_sequence,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_attr_bits,
    output logic [1:0]  o_fg_kind,
    output logic [23:0] o_fg_value,
    output logic [1:0]  o_bg_kind,
    output logic [23:0] o_bg_value,
    output logic        o_pen_valid
);

    // input register
    logic        r_in_valid;
    logic [15:0] r_in_value;
    logic        r_in_omitted;
    logic        r_in_last;
    logic        r_in_empty;

    // pen state, doubles as the result register
    sgrpen_pkg::t_pen r_pen;
    sgrpen_pkg::t_pen n_pen;
    logic             r_out_valid;

    logic in_xfer;
    logic advance;

    // the pen may move on when the current result is gone or leaves now
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    sgrpen_step u_step (
        .i_pen            (r_pen),
        .i_param_value    (r_in_value),
        .i_param_omitted  (r_in_omitted),
        .i_last_param     (r_in_last),
        .i_empty_sequence (r_in_empty),
        .o_pen            (n_pen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_value   <= i_param_value;
            r_in_omitted <= i_param_omitted;
            r_in_last    <= i_last_param;
            r_in_empty   <= i_empty_sequence;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen       <= sgrpen_pkg::PEN_RESET;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_pen       <= n_pen;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_attr_bits = r_pen.attrs;
    assign o_fg_kind   = r_pen.fg_kind;
    assign o_fg_value  = r_pen.fg_value;
    assign o_bg_kind   = r_pen.bg_kind;
    assign o_bg_value  = r_pen.bg_value;
    assign o_pen_valid = (r_pen.phase == sgrpen_pkg::PH_IDLE);

endmodule

/* sim/tb_sgr_pen_attribute_decoder_top.sv */
module tb_sgr_pen_attribute_decoder_top;

    // attribute codes and limits that the package does not name
    localparam logic [15:0] SGR_BOLD          = 16'd1;
    localparam logic [15:0] SGR_NOT_BOLD_DIM  = 16'd22;
    localparam logic [15:0] SGR_GAP_CODE      = 16'd26;
    localparam logic [15:0] CHAN_MAX          = 16'd255;
    localparam logic [15:0] PARAM_MAX         = 16'hFFFF;

    localparam int N_ITEMS    = 750;
    localparam int IDLE_PCT   = 16;
    localparam int HOLD_LEN   = 60;
    localparam int DRAIN_CYC  = 20;
    localparam int Q_DEPTH    = 1024;
    localparam int SEQ_MAX    = 32;

    // one sgr parameter as offered on the input channel
    typedef struct {
        logic [15:0] value;
        logic        omitted;
        logic        last;
        logic        empty;
    } t_param;

    // the pen as reported after one parameter
    typedef struct {
        logic [7:0]  attrs;
        logic [1:0]  fg_kind;
        logic [23:0] fg_value;
        logic [1:0]  bg_kind;
        logic [23:0] bg_value;
        logic        pen_valid;
    } t_pen_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] param_value = '0;
    logic        param_omitted = 1'b0;
    logic        last_param = 1'b0;
    logic        empty_sequence = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  attr_bits;
    logic [1:0]  fg_kind;
    logic [23:0] fg_value;
    logic [1:0]  bg_kind;
    logic [23:0] bg_value;
    logic        pen_valid;

    t_param      param_mem [0:Q_DEPTH-1];   // parameters, offered from param_rd on
    int          param_wr = 0;
    int          param_rd = 0;
    t_pen_report pen_mem [0:Q_DEPTH-1];     // pens predicted, checked from pen_rd on
    int          pen_wr = 0;
    int          pen_rd = 0;
    t_param      seq_buf [0:SEQ_MAX-1];     // sequence under construction
    int          seq_len = 0;
    int          errors = 0;
    int          pens_seen = 0;
    int          hold_left = 0;
    int          cycle_cnt = 0;

    // predicted pen state
    logic [7:0]             pen_attrs = '0;
    logic [1:0]             fore_kind = sgrpen_pkg::KIND_DEFAULT;
    logic [23:0]            fore_val = '0;
    logic [1:0]             back_kind = sgrpen_pkg::KIND_DEFAULT;
    logic [23:0]            back_val = '0;
    logic                   ext_back = 1'b0;
    sgrpen_pkg::t_ext_phase ext_phase = sgrpen_pkg::PH_IDLE;
    logic [15:0]            rgb_so_far = '0;

    sgr_pen_attribute_decoder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_param_value    (param_value),
        .i_param_omitted  (param_omitted),
        .i_last_param     (last_param),
        .i_empty_sequence (empty_sequence),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_attr_bits      (attr_bits),
        .o_fg_kind        (fg_kind),
        .o_fg_value       (fg_value),
        .o_bg_kind        (bg_kind),
        .o_bg_value       (bg_value),
        .o_pen_valid      (pen_valid)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // a stretch in the middle of the run where neither side idles at random
    function automatic logic calm_stretch();
        return cycle_cnt >= 400 && cycle_cnt < 900;
    endfunction

    function automatic logic [7:0] chan_clamp(logic [15:0] v);
        return (v > CHAN_MAX) ? 8'hFF : v[7:0];
    endfunction

    // attribute bit set by selector digit n (1..9), both blink codes share a bit
    function automatic logic [7:0] set_mask(logic [3:0] n);
        case (n)
            4'd1: return 8'h01;
            4'd2: return 8'h02;
            4'd3: return 8'h04;
            4'd4: return 8'h08;
            4'd5, 4'd6: return 8'h10;
            4'd7: return 8'h20;
            4'd8: return 8'h40;
            4'd9: return 8'h80;
            default: return 8'h00;
        endcase
    endfunction

    // clear codes: 21 and 22 both drop bold and dim, 26 does nothing
    function automatic logic [7:0] clear_mask(logic [3:0] n);
        if (n == 4'd1 || n == 4'd2) return 8'h03;
        if (n == 4'd6) return 8'h00;
        return set_mask(n);
    endfunction

    task automatic put_fg(logic [1:0] k, logic [23:0] v);
        fore_kind = k;
        fore_val  = v;
    endtask

    task automatic put_bg(logic [1:0] k, logic [23:0] v);
        back_kind = k;
        back_val  = v;
    endtask

    // completes the pending extended colour
    task automatic close_ext(logic [1:0] k, logic [23:0] v);
        if (ext_back) put_bg(k, v);
        else put_fg(k, v);
        ext_phase  = sgrpen_pkg::PH_IDLE;
        rgb_so_far = '0;
    endtask

    task automatic plain_sgr(logic [15:0] code);
        logic [15:0] ofs;
        ofs = code - sgrpen_pkg::SGR_CLR_BASE;
        if (code == sgrpen_pkg::SGR_RESET) begin
            pen_attrs = '0;
            put_fg(sgrpen_pkg::KIND_DEFAULT, '0);
            put_bg(sgrpen_pkg::KIND_DEFAULT, '0);
        end else if (code <= sgrpen_pkg::SGR_SET_LAST) begin
            pen_attrs |= set_mask(code[3:0]);
        end else if (code > sgrpen_pkg::SGR_CLR_BASE && code <= sgrpen_pkg::SGR_CLR_LAST) begin
            pen_attrs &= ~clear_mask(ofs[3:0]);
        end else if (code >= sgrpen_pkg::SGR_FG_BASE && code <= sgrpen_pkg::SGR_FG_LAST) begin
            put_fg(sgrpen_pkg::KIND_PALETTE, 24'(code - sgrpen_pkg::SGR_FG_BASE));
        end else if (code == sgrpen_pkg::SGR_EXT_FG || code == sgrpen_pkg::SGR_EXT_BG) begin
            ext_back   = (code == sgrpen_pkg::SGR_EXT_BG);
            ext_phase  = sgrpen_pkg::PH_KIND;
            rgb_so_far = '0;
        end else if (code == sgrpen_pkg::SGR_DEFAULT_FG) begin
            put_fg(sgrpen_pkg::KIND_DEFAULT, '0);
        end else if (code >= sgrpen_pkg::SGR_BG_BASE && code <= sgrpen_pkg::SGR_BG_LAST) begin
            put_bg(sgrpen_pkg::KIND_PALETTE, 24'(code - sgrpen_pkg::SGR_BG_BASE));
        end else if (code == sgrpen_pkg::SGR_DEFAULT_BG) begin
            put_bg(sgrpen_pkg::KIND_DEFAULT, '0);
        end else if (code >= sgrpen_pkg::SGR_FG_BRIGHT_BASE &&
                     code <= sgrpen_pkg::SGR_FG_BRIGHT_LAST) begin
            put_fg(sgrpen_pkg::KIND_PALETTE,
                   24'(code - sgrpen_pkg::SGR_FG_BRIGHT_BASE + 16'd8));
        end else if (code >= sgrpen_pkg::SGR_BG_BRIGHT_BASE &&
                     code <= sgrpen_pkg::SGR_BG_BRIGHT_LAST) begin
            put_bg(sgrpen_pkg::KIND_PALETTE,
                   24'(code - sgrpen_pkg::SGR_BG_BRIGHT_BASE + 16'd8));
        end
    endtask

    // advances the pen by one accepted parameter and queues the pen it reports
    task automatic predict_pen(t_param p);
        logic [15:0] v;
        t_pen_report r;
        v = p.omitted ? 16'd0 : p.value;
        if (p.empty) begin
            pen_attrs  = '0;
            put_fg(sgrpen_pkg::KIND_DEFAULT, '0);
            put_bg(sgrpen_pkg::KIND_DEFAULT, '0);
            ext_back   = 1'b0;
            ext_phase  = sgrpen_pkg::PH_IDLE;
            rgb_so_far = '0;
        end else begin
            case (ext_phase)
                sgrpen_pkg::PH_KIND: begin
                    if (v == sgrpen_pkg::EXT_KIND_INDEX) ext_phase = sgrpen_pkg::PH_INDEX;
                    else if (v == sgrpen_pkg::EXT_KIND_RGB)
                        ext_phase = sgrpen_pkg::PH_RED_OR_SLOT;
                    else close_ext(sgrpen_pkg::KIND_DEFAULT, '0);
                end
                sgrpen_pkg::PH_INDEX: close_ext(sgrpen_pkg::KIND_PALETTE, 24'(chan_clamp(v)));
                sgrpen_pkg::PH_RED_OR_SLOT: begin
                    // an omitted first operand is the colourspace slot
                    if (p.omitted) begin
                        ext_phase = sgrpen_pkg::PH_RED;
                    end else begin
                        rgb_so_far = {chan_clamp(v), 8'h00};
                        ext_phase  = sgrpen_pkg::PH_GREEN;
                    end
                end
                sgrpen_pkg::PH_RED: begin
                    rgb_so_far = {chan_clamp(v), 8'h00};
                    ext_phase  = sgrpen_pkg::PH_GREEN;
                end
                sgrpen_pkg::PH_GREEN: begin
                    rgb_so_far[7:0] = chan_clamp(v);
                    ext_phase = sgrpen_pkg::PH_BLUE;
                end
                sgrpen_pkg::PH_BLUE: close_ext(sgrpen_pkg::KIND_RGB, {rgb_so_far, chan_clamp(v)});
                default: begin
                    ext_phase = sgrpen_pkg::PH_IDLE;
                    plain_sgr(v);
                end
            endcase
            // sequence ended early: missing operands read as zero
            if (p.last && ext_phase != sgrpen_pkg::PH_IDLE) begin
                case (ext_phase)
                    sgrpen_pkg::PH_KIND:  close_ext(sgrpen_pkg::KIND_DEFAULT, '0);
                    sgrpen_pkg::PH_INDEX: close_ext(sgrpen_pkg::KIND_PALETTE, '0);
                    default:  close_ext(sgrpen_pkg::KIND_RGB, {rgb_so_far, 8'h00});
                endcase
            end
        end
        r.attrs     = pen_attrs;
        r.fg_kind   = fore_kind;
        r.fg_value  = fore_val;
        r.bg_kind   = back_kind;
        r.bg_value  = back_val;
        r.pen_valid = (ext_phase == sgrpen_pkg::PH_IDLE);
        pen_mem[pen_wr] = r;
        pen_wr++;
    endtask

    task automatic queue_param(t_param p);
        param_mem[param_wr] = p;
        param_wr++;
    endtask

    task automatic push_param(logic [15:0] v, logic om, logic lst);
        t_param p;
        p.value   = v;
        p.omitted = om;
        p.last    = lst;
        p.empty   = 1'b0;
        queue_param(p);
    endtask

    // empty sequence, other fields random since they are ignored
    task automatic push_empty();
        t_param p;
        p.value   = 16'($urandom_range(0, 65535));
        p.omitted = 1'($urandom_range(0, 1));
        p.last    = 1'($urandom_range(0, 1));
        p.empty   = 1'b1;
        queue_param(p);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(sgrpen_pkg::SGR_RESET, sgrpen_pkg::SGR_SET_LAST));
            1: return 16'($urandom_range(sgrpen_pkg::SGR_CLR_BASE + 1,
                                         sgrpen_pkg::SGR_CLR_LAST));
            2: return 16'($urandom_range(sgrpen_pkg::SGR_FG_BASE, sgrpen_pkg::SGR_FG_LAST));
            3: return 16'($urandom_range(sgrpen_pkg::SGR_BG_BASE, sgrpen_pkg::SGR_BG_LAST));
            4: return 16'($urandom_range(sgrpen_pkg::SGR_FG_BRIGHT_BASE,
                                         sgrpen_pkg::SGR_FG_BRIGHT_LAST));
            5: return 16'($urandom_range(sgrpen_pkg::SGR_BG_BRIGHT_BASE,
                                         sgrpen_pkg::SGR_BG_BRIGHT_LAST));
            6: return $urandom_range(0, 1) ? sgrpen_pkg::SGR_DEFAULT_FG
                                           : sgrpen_pkg::SGR_DEFAULT_BG;
            7: return 16'($urandom_range(0, 127));
            8: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(sgrpen_pkg::SGR_SET_LAST + 1,
                                               sgrpen_pkg::SGR_CLR_BASE));
        endcase
    endfunction

    // colour operand: mostly in range, sometimes past the clamp
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return CHAN_MAX;
            1: return CHAN_MAX + 16'd1;
            2: return 16'($urandom_range(256, 65535));
            3: return PARAM_MAX;
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic seq_add(logic [15:0] v, logic om);
        t_param p;
        p.value   = v;
        p.omitted = om;
        p.last    = 1'b0;
        p.empty   = 1'b0;
        seq_buf[seq_len] = p;
        seq_len++;
    endtask

    // one random sequence, mostly well formed, sometimes cut short or unfinished
    task automatic add_sequence();
        int n;
        int k;
        int cut;
        n = $urandom_range(1, 5);
        seq_len = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 30) begin
                seq_add($urandom_range(0, 1) ? sgrpen_pkg::SGR_EXT_BG : sgrpen_pkg::SGR_EXT_FG,
                        1'b0);
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    seq_add(sgrpen_pkg::EXT_KIND_INDEX, 1'b0);
                    seq_add(pick_operand(), 1'($urandom_range(0, 19) == 0));
                end else if (k < 8) begin
                    seq_add(sgrpen_pkg::EXT_KIND_RGB, 1'b0);
                    if ($urandom_range(0, 1))
                        seq_add(16'($urandom_range(0, 65535)), 1'b1);
                    for (int c = 0; c < 3; c++)
                        seq_add(pick_operand(), 1'($urandom_range(0, 19) == 0));
                end else begin
                    // unsupported or omitted kind
                    seq_add(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 2) == 0));
                end
            end else begin
                seq_add(pick_code(), 1'($urandom_range(0, 19) == 0));
            end
            // omitted parameters carry random value bits
            if (seq_buf[seq_len - 1].omitted)
                seq_buf[seq_len - 1].value = 16'($urandom_range(0, 65535));
        end
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, seq_len);
            if (seq_len > cut) seq_len = cut;
        end
        if ($urandom_range(0, 99) >= 5)
            seq_buf[seq_len - 1].last = 1'b1;
        for (int i = 0; i < seq_len; i++) queue_param(seq_buf[i]);
        if ($urandom_range(0, 99) < 5) push_empty();
    endtask

    // sender: holds a transfer until taken, idles at random between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_pen(param_mem[param_rd]);
                param_rd++;
            end
            if (!(in_valid && in_stall)) begin
                if (param_rd != param_wr &&
                    (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid       <= 1'b1;
                    param_value    <= param_mem[param_rd].value;
                    param_omitted  <= param_mem[param_rd].omitted;
                    last_param     <= param_mem[param_rd].last;
                    empty_sequence <= param_mem[param_rd].empty;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_pen();
        t_pen_report e;
        if (pen_rd == pen_wr) begin
            $display("%0t: pen transfer with nothing expected", $time);
            errors++;
            return;
        end
        e = pen_mem[pen_rd];
        pen_rd++;
        if (attr_bits !== e.attrs) begin
            $display("%0t: attr_bits expected %h got %h", $time, e.attrs, attr_bits);
            errors++;
        end
        if (fg_kind !== e.fg_kind) begin
            $display("%0t: fg_kind expected %0d got %0d", $time, e.fg_kind, fg_kind);
            errors++;
        end
        if (fg_value !== e.fg_value) begin
            $display("%0t: fg_value expected %h got %h", $time, e.fg_value, fg_value);
            errors++;
        end
        if (bg_kind !== e.bg_kind) begin
            $display("%0t: bg_kind expected %0d got %0d", $time, e.bg_kind, bg_kind);
            errors++;
        end
        if (bg_value !== e.bg_value) begin
            $display("%0t: bg_value expected %h got %h", $time, e.bg_value, bg_value);
            errors++;
        end
        if (pen_valid !== e.pen_valid) begin
            $display("%0t: pen_valid expected %b got %b", $time, e.pen_valid, pen_valid);
            errors++;
        end
    endtask

    // receiver: checks each pen transfer, stalls at random, and twice holds off
    // for a long stretch so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                check_pen();
                pens_seen++;
                if (pens_seen == 250 || pens_seen == 550)
                    hold_left = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm_stretch() && $urandom_range(0, 99) < IDLE_PCT;
            end
        end
    end

    initial begin
        // directed: empty sequence first, then attribute and colour corners
        push_empty();
        push_param(SGR_BOLD, 1'b0, 1'b1);
        push_param(SGR_NOT_BOLD_DIM, 1'b0, 1'b1);
        push_param(SGR_GAP_CODE, 1'b0, 1'b1);
        push_param(sgrpen_pkg::SGR_FG_LAST, 1'b0, 1'b1);
        push_param(sgrpen_pkg::SGR_BG_BRIGHT_LAST, 1'b0, 1'b1);
        push_param(PARAM_MAX, 1'b1, 1'b1);
        // palette index past the clamp
        push_param(sgrpen_pkg::SGR_EXT_FG, 1'b0, 1'b0);
        push_param(sgrpen_pkg::EXT_KIND_INDEX, 1'b0, 1'b0);
        push_param(16'd300, 1'b0, 1'b1);
        // rgb with skipped colourspace slot, green clamped
        push_param(sgrpen_pkg::SGR_EXT_BG, 1'b0, 1'b0);
        push_param(sgrpen_pkg::EXT_KIND_RGB, 1'b0, 1'b0);
        push_param(PARAM_MAX, 1'b1, 1'b0);
        push_param(CHAN_MAX, 1'b0, 1'b0);
        push_param(PARAM_MAX, 1'b0, 1'b0);
        push_param(16'd7, 1'b0, 1'b1);
        // unsupported kind gives default colour
        push_param(sgrpen_pkg::SGR_EXT_BG, 1'b0, 1'b0);
        push_param(16'd9, 1'b0, 1'b1);
        // truncated extended colours
        push_param(sgrpen_pkg::SGR_EXT_FG, 1'b0, 1'b1);
        push_param(sgrpen_pkg::SGR_EXT_BG, 1'b0, 1'b0);
        push_param(sgrpen_pkg::EXT_KIND_INDEX, 1'b0, 1'b1);
        push_param(sgrpen_pkg::SGR_EXT_FG, 1'b0, 1'b0);
        push_param(sgrpen_pkg::EXT_KIND_RGB, 1'b0, 1'b0);
        push_param(16'd9, 1'b0, 1'b1);
        // empty sequence drops a pending colour
        push_param(sgrpen_pkg::SGR_EXT_FG, 1'b0, 1'b0);
        push_empty();
        while (param_wr < N_ITEMS) add_sequence();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all parameters taken, then all pens seen
        while (param_rd != param_wr || in_valid) @(posedge i_clk);
        while (pen_rd != pen_wr) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("sgr_pen_attribute_decoder_top test passed");
        end else begin
            $display("sgr_pen_attribute_decoder_top test failed");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("sgr_pen_attribute_decoder_top test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/sgrpen_pkg.sv
rtl/sgrpen_step.sv
rtl/sgr_pen_attribute_decoder_top.sv
sim/tb_sgr_pen_attribute_decoder_top.sv
